// ----- rtl/ics_pkg.sv -----
// ----------------------------------------------------------------------------
// Internet checksum stream package
// Shared types and constants for the streaming ones' complement checksum.
// ----------------------------------------------------------------------------
`default_nettype none

package ics_pkg;

   localparam int MAX_PACKET_BYTES = 2048;
   localparam int COUNT_WIDTH      = $clog2(MAX_PACKET_BYTES + 1);
   localparam int WORD_BITS        = 16;
   localparam int BYTE_BITS        = 8;
   localparam int SUM_BITS         = WORD_BITS + 1;
   localparam int TOTAL_BITS       = WORD_BITS + 3;
   localparam int PSEUDO_BIAS      = 8;
   localparam int SHORT_BIAS       = PSEUDO_BIAS + 1;
   localparam int PROTO_UDP        = 17;
   localparam int PROTO_TCP        = 6;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_UDP   = 2'd1,
      MODE_TCP   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic [1:0] action;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] checksum_value;
      logic        short_packet;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ----- rtl/internet_checksum_stream.sv -----
// A last byte's sums are registered in the finishing stage, then in the result register that drives rsp.
// Throughput: one byte per cycle while the input is not stalled; bytes that are not last give no result.
// The input stalls only when both the finishing stage and the result register
// are full and the result is stalled. Reset clears the running packet state
// and both result stages; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Internet checksum stream
// Pairs packet bytes into big-endian words, keeps a ones' complement sum with
// a deferred carry, adds the UDP or TCP pseudo-header terms and folds on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module internet_checksum_stream (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  ics_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output ics_pkg::rsp_payload_type rsp_payload
);

   import ics_pkg::*;

   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [BYTE_BITS-1:0]   hold_ff, hold_in;
   logic                   odd_ff, odd_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   mode_type               mode_ff, mode_in;

   logic                   fin_valid_ff, fin_valid_in;
   logic [SUM_BITS-1:0]    fin_sum_ff, fin_sum_in;
   logic [WORD_BITS-1:0]   fin_word_ff, fin_word_in;
   logic [COUNT_WIDTH-1:0] fin_count_ff, fin_count_in;
   mode_type               fin_mode_ff, fin_mode_in;

   logic                   tot_valid_ff, tot_valid_in;
   logic [TOTAL_BITS-1:0]  tot_sum_ff, tot_sum_in;
   logic                   tot_short_ff, tot_short_in;

   logic                   accept;
   logic                   tot_load;
   logic                   fin_load;
   mode_type               act_mode;
   mode_type               cur_mode;
   logic [WORD_BITS-1:0]   cur_word;
   logic [COUNT_WIDTH-1:0] count_next;
   logic                   pseudo;
   logic                   short_pkt;
   logic [WORD_BITS-1:0]   proto_term;
   logic [WORD_BITS-1:0]   len_term;
   logic [WORD_BITS-1:0]   count_word;
   logic [WORD_BITS:0]     fold1;
   logic [WORD_BITS-1:0]   fold2;

   assign tot_load  = !tot_valid_ff || !rsp_stall;
   assign fin_load  = !fin_valid_ff || tot_load;
   assign req_stall = !fin_load;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      unique case (req_payload.action)
         MODE_UDP: act_mode = MODE_UDP;
         MODE_TCP: act_mode = MODE_TCP;
         default:  act_mode = MODE_PLAIN;
      endcase
   end

   always_comb begin
      cur_mode   = (count_ff == '0 && !odd_ff) ? act_mode : mode_ff;
      cur_word   = odd_ff ? {hold_ff, req_payload.data_byte}
                          : {req_payload.data_byte, {BYTE_BITS{1'b0}}};
      count_next = (count_ff < COUNT_WIDTH'(MAX_PACKET_BYTES)) ? count_ff + 1'b1 : count_ff;

      sum_in       = sum_ff;
      hold_in      = hold_ff;
      odd_in       = odd_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      fin_valid_in = fin_valid_ff && !tot_load;
      fin_sum_in   = fin_sum_ff;
      fin_word_in  = fin_word_ff;
      fin_count_in = fin_count_ff;
      fin_mode_in  = fin_mode_ff;

      if (accept) begin
         if (req_payload.last_byte) begin
            fin_valid_in = 1'b1;
            fin_sum_in   = sum_ff;
            fin_word_in  = cur_word;
            fin_count_in = count_next;
            fin_mode_in  = cur_mode;
            sum_in       = '0;
            hold_in      = '0;
            odd_in       = 1'b0;
            count_in     = '0;
            mode_in      = MODE_PLAIN;
         end else begin
            if (odd_ff) begin
               sum_in = {1'b0, sum_ff[WORD_BITS-1:0]}
                      + {{WORD_BITS{1'b0}}, sum_ff[WORD_BITS]}
                      + {1'b0, cur_word};
               odd_in = 1'b0;
            end else begin
               hold_in = req_payload.data_byte;
               odd_in  = 1'b1;
            end
            count_in = count_next;
            mode_in  = cur_mode;
         end
      end
   end

   always_comb begin
      pseudo     = (fin_mode_ff == MODE_UDP) || (fin_mode_ff == MODE_TCP);
      short_pkt  = pseudo && (fin_count_ff < COUNT_WIDTH'(PSEUDO_BIAS));
      count_word = {{(WORD_BITS-COUNT_WIDTH){1'b0}}, fin_count_ff};
      proto_term = '0;
      len_term   = '0;
      if (pseudo) begin
         proto_term = (fin_mode_ff == MODE_UDP) ? WORD_BITS'(PROTO_UDP)
                                                : WORD_BITS'(PROTO_TCP);
         len_term   = count_word - (short_pkt ? WORD_BITS'(SHORT_BIAS)
                                              : WORD_BITS'(PSEUDO_BIAS));
      end

      tot_valid_in = tot_valid_ff && rsp_stall;
      tot_sum_in   = tot_sum_ff;
      tot_short_in = tot_short_ff;
      if (fin_valid_ff && tot_load) begin
         tot_valid_in = 1'b1;
         tot_sum_in   = {2'b00, fin_sum_ff}
                      + {3'b000, fin_word_ff}
                      + {3'b000, proto_term}
                      + {3'b000, len_term};
         tot_short_in = short_pkt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         hold_ff      <= '0;
         odd_ff       <= 1'b0;
         count_ff     <= '0;
         mode_ff      <= MODE_PLAIN;
         fin_valid_ff <= 1'b0;
         tot_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         hold_ff      <= hold_in;
         odd_ff       <= odd_in;
         count_ff     <= count_in;
         mode_ff      <= mode_in;
         fin_valid_ff <= fin_valid_in;
         tot_valid_ff <= tot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_sum_ff   <= fin_sum_in;
      fin_word_ff  <= fin_word_in;
      fin_count_ff <= fin_count_in;
      fin_mode_ff  <= fin_mode_in;
      tot_sum_ff   <= tot_sum_in;
      tot_short_ff <= tot_short_in;
   end

   assign fold1 = {1'b0, tot_sum_ff[WORD_BITS-1:0]}
                + {{(WORD_BITS-2){1'b0}}, tot_sum_ff[TOTAL_BITS-1:WORD_BITS]};
   assign fold2 = fold1[WORD_BITS-1:0] + {{(WORD_BITS-1){1'b0}}, fold1[WORD_BITS]};

   assign rsp_valid                  = tot_valid_ff;
   assign rsp_payload.checksum_value = ~fold2;
   assign rsp_payload.short_packet   = tot_short_ff;

endmodule

`default_nettype wire

// ----- rtl/ics_checker.sv -----
// ----------------------------------------------------------------------------
// Internet checksum stream checker
// Port-level assertions on the checksum stream, bound into internet_checksum_stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ics_checker (
   input wire                      clock,
   input wire                      reset,
   input wire                      req_valid,
   input wire                      req_stall,
   input ics_pkg::req_payload_type req_payload,
   input wire                      rsp_valid,
   input wire                      rsp_stall,
   input ics_pkg::rsp_payload_type rsp_payload
);

   import ics_pkg::*;

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled result changed or was dropped.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_payload.last_byte, 2))
      else $error("Result appeared without a last byte transfer two cycles before.");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("Input stalled while the result side was free.");

endmodule

bind internet_checksum_stream ics_checker u_ics_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Internet checksum stream testbench
// Sends packets byte by byte in plain, UDP and TCP modes and compares every
// checksum result with a cycle-free model of the ones' complement sum that
// runs alongside the block. The input and result sides pause at random, and
// at one point the result side is held off long enough to stall the input.
// ----------------------------------------------------------------------------

module tb_top;

   import ics_pkg::*;

   localparam logic [1:0] ACTION_UNUSED = 2'd3;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_EXTREME} fill_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic rsp_hold = 1'b0;
   int mismatch_count = 0;

   rsp_payload_type expected_checksums[$];

   logic [15:0]            sum_acc = '0;
   logic [7:0]             pending_high = '0;
   logic                   pending = 1'b0;
   logic [COUNT_WIDTH-1:0] bytes_seen = '0;
   mode_type               cur_mode = MODE_PLAIN;

   internet_checksum_stream dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[15:0] + {15'd0, total[16]};
   endfunction

   function automatic void note_failure(string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("MISMATCH at %0t: %s", $time, what);
      end
   endfunction

   function automatic logic [7:0] pick_byte(fill_type fill);
      case (fill)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         FILL_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void predict_checksum(req_payload_type item);
      rsp_payload_type result;
      logic pseudo;
      if (bytes_seen == 0 && !pending) begin
         cur_mode = (item.action == ACTION_UNUSED) ? MODE_PLAIN : mode_type'(item.action);
      end
      if (!pending) begin
         pending_high = item.data_byte;
         pending = 1'b1;
      end else begin
         sum_acc = ones_add(sum_acc, {pending_high, item.data_byte});
         pending = 1'b0;
      end
      if (bytes_seen < MAX_PACKET_BYTES) begin
         bytes_seen++;
      end
      if (item.last_byte) begin
         if (pending) begin
            sum_acc = ones_add(sum_acc, {pending_high, 8'h00});
         end
         pseudo = (cur_mode == MODE_UDP) || (cur_mode == MODE_TCP);
         result.short_packet = pseudo && (bytes_seen < PSEUDO_BIAS);
         if (pseudo) begin
            sum_acc = ones_add(sum_acc,
                               (cur_mode == MODE_UDP) ? 16'(PROTO_UDP) : 16'(PROTO_TCP));
            if (bytes_seen >= PSEUDO_BIAS) begin
               sum_acc = ones_add(sum_acc, 16'(bytes_seen - PSEUDO_BIAS));
            end else begin
               sum_acc = ones_add(sum_acc, 16'hFFFF - 16'(PSEUDO_BIAS - bytes_seen));
            end
         end
         result.checksum_value = ~sum_acc;
         expected_checksums.push_back(result);
         sum_acc = '0;
         pending_high = '0;
         pending = 1'b0;
         bytes_seen = '0;
         cur_mode = MODE_PLAIN;
      end
   endfunction

   task automatic send_byte(input req_payload_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_checksum(item);
   endtask

   task automatic send_packet(input logic [1:0] action, input int len, input fill_type fill);
      req_payload_type item;
      for (int i = 0; i < len; i++) begin
         item.data_byte = pick_byte(fill);
         item.last_byte = (i == len - 1);
         item.action = (i == 0) ? action : 2'($urandom_range(0, 3));
         send_byte(item);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= rsp_hold || ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_payload_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_checksums.size() == 0) begin
            note_failure($sformatf("result %h arrived with none expected", rsp_payload));
         end else begin
            wanted = expected_checksums.pop_front();
            if (rsp_payload.checksum_value !== wanted.checksum_value) begin
               note_failure($sformatf("checksum_value expected %h, got %h",
                                      wanted.checksum_value, rsp_payload.checksum_value));
            end
            if (rsp_payload.short_packet !== wanted.short_packet) begin
               note_failure($sformatf("short_packet expected %b, got %b",
                                      wanted.short_packet, rsp_payload.short_packet));
            end
         end
      end
   end

   // An all-zero packet must give 0xFFFF and an all-ones packet 0x0000.
   task automatic test_plain_sums();
      send_packet(MODE_PLAIN, 2, FILL_ZERO);
      send_packet(MODE_PLAIN, 2, FILL_ONES);
      send_packet(MODE_PLAIN, 1, FILL_RANDOM);
      send_packet(ACTION_UNUSED, 2, FILL_ONES);
   endtask

   task automatic test_pseudo_headers();
      send_packet(MODE_UDP, 8, FILL_RANDOM);
      send_packet(MODE_TCP, 3, FILL_RANDOM);
      send_packet(MODE_UDP, 1, FILL_ZERO);
      send_packet(MODE_TCP, 7, FILL_ONES);
   endtask

   task automatic test_overlong_packet();
      send_packet(MODE_UDP, MAX_PACKET_BYTES + $urandom_range(1, 6), FILL_RANDOM);
   endtask

   // Short packets fill the result stages while the result side is held off, so the input stalls.
   task automatic test_result_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         begin
            for (int i = 0; i < 40; i++) begin
               send_packet(2'($urandom_range(0, 3)), $urandom_range(1, 2), FILL_RANDOM);
            end
         end
      join
   endtask

   task automatic test_random_packets(input int byte_budget, input int send_pct,
                                      input int rsp_pct);
      int sent;
      int len;
      fill_type fill;
      sent = 0;
      send_idle_pct = send_pct;
      rsp_stall_pct = rsp_pct;
      while (sent < byte_budget) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
         fill = ($urandom_range(0, 7) == 0) ? FILL_EXTREME : FILL_RANDOM;
         send_packet(2'($urandom_range(0, 3)), len, fill);
         sent += len;
      end
   endtask

   initial begin
      int waited;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_plain_sums();
      test_pseudo_headers();
      test_overlong_packet();
      test_result_backpressure();
      test_random_packets(350, 19, 52);
      test_random_packets(350, 52, 19);
      test_random_packets(350, 0, 0);
      req_valid <= 1'b0;
      waited = 0;
      while (expected_checksums.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (6) @(posedge clock);
      if (expected_checksums.size() != 0) begin
         note_failure($sformatf("%0d expected results never arrived",
                                expected_checksums.size()));
      end
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
